### sv/ssts_pkg.sv
package ssts_pkg;

  // Fixed display geometry: eight select pins and one segment byte.
  localparam int MAX_DIGITS   = 8;
  localparam int SEGMENT_BITS = 8;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EOS   = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_GLYPH = 2'd3
  } kind_e;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [2:0] {
    REG_DIGIT_COUNT     = 3'd0,
    REG_DIGIT_PIN_MAP   = 3'd1,
    REG_SEGMENT_COUNT   = 3'd2,
    REG_SEGMENT_PIN_MAP = 3'd3,
    REG_DOT_BIT         = 3'd4,
    REG_FILL_PATTERN    = 3'd5,
    REG_SPARE6          = 3'd6,
    REG_SPARE7          = 3'd7
  } reg_e;

  // Register reset values.
  localparam logic [3:0]  RST_DIGIT_COUNT     = 4'd4;
  localparam logic [23:0] RST_DIGIT_PIN_MAP   = 24'hFAC688;
  localparam logic [3:0]  RST_SEGMENT_COUNT   = 4'd8;
  localparam logic [23:0] RST_SEGMENT_PIN_MAP = 24'hFAC688;
  localparam logic [2:0]  RST_DOT_BIT         = 3'd2;
  localparam logic [7:0]  RST_FILL_PATTERN    = 8'h00;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_UNDER  = 8'h5F;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  // Fixed logical patterns of the punctuation marks.
  localparam logic [7:0] PAT_CARET  = 8'h02;
  localparam logic [7:0] PAT_COMMA  = 8'h04;
  localparam logic [7:0] PAT_MINUS  = 8'h40;
  localparam logic [7:0] PAT_UNDER  = 8'h08;
  localparam logic [7:0] PAT_EQUALS = 8'h48;
  localparam logic [7:0] PAT_PERIOD = 8'h80;
  localparam logic [7:0] PAT_BLANK  = 8'h00;

  // Work handed from the item stage to the digit bank.
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic       is_period;
    logic [7:0] pattern;
  } digit_cmd_t;

  // One scan result.
  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segment_drive;
    logic [2:0] scan_digit;
  } scan_res_t;

  // Logical pattern of a character that does not use the glyph table.
  function automatic logic [7:0] punct_pattern(input logic [7:0] c);
    logic [7:0] p;
    case (c)
      CHAR_CARET:  p = PAT_CARET;
      CHAR_COMMA:  p = PAT_COMMA;
      CHAR_MINUS:  p = PAT_MINUS;
      CHAR_UNDER:  p = PAT_UNDER;
      CHAR_EQUALS: p = PAT_EQUALS;
      CHAR_PERIOD: p = PAT_PERIOD;
      default:     p = PAT_BLANK;
    endcase
    return p;
  endfunction

  // Move each logical segment bit onto its physical pin, then invert for active-low drive.
  function automatic logic [7:0] remap_segments(input logic [7:0]  logical,
                                                input logic [3:0]  seg_count,
                                                input logic [23:0] seg_map);
    logic [3:0] n;
    logic [7:0] mapped;
    n = (seg_count > 4'(SEGMENT_BITS)) ? 4'(SEGMENT_BITS) : seg_count;
    mapped = '0;
    for (int i = 0; i < SEGMENT_BITS; i++) begin
      if ((4'(i) < n) && logical[i]) begin
        mapped[seg_map[3*i +: 3]] = 1'b1;
      end
    end
    return ~mapped;
  endfunction

endpackage

### sv/ssts_in_if.sv
interface ssts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [5:0] glyph_index;
  logic [7:0] glyph_pattern;

  modport source (output valid, kind, char_code, glyph_index, glyph_pattern, input ready);
  modport sink   (input valid, kind, char_code, glyph_index, glyph_pattern, output ready);
endinterface

### sv/ssts_out_if.sv
interface ssts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_select;
  logic [7:0] segment_drive;
  logic [2:0] scan_digit;

  modport source (output valid, digit_select, segment_drive, scan_digit, input ready);
  modport sink   (input valid, digit_select, segment_drive, scan_digit, output ready);
endinterface

### sv/ssts_glyph_ram.sv
module ssts_glyph_ram #(
  parameter int DEPTH = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/ssts_digit_bank.sv
module ssts_digit_bank (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssts_pkg::digit_cmd_t   cmd_i,
  input  logic [3:0]             count_i,
  input  logic [23:0]            digit_pin_map_i,
  input  logic [2:0]             dot_bit_i,
  input  logic [7:0]             fill_pattern_i,
  output ssts_pkg::scan_res_t    res_o
);

  logic [7:0] pat_q [ssts_pkg::MAX_DIGITS];
  logic [7:0] pat_d [ssts_pkg::MAX_DIGITS];
  logic [3:0] wp_q, wp_d;
  logic [2:0] sp_q, sp_d;
  logic [3:0] next_w;
  logic [2:0] next3;
  logic [2:0] pin;
  logic [3:0] wp_prev;

  // Next scan position wraps to digit 0 at the digit count.
  always_comb begin
    next_w = {1'b0, sp_q} + 4'd1;
    if (next_w >= count_i) begin
      next_w = 4'd0;
    end
    next3 = next_w[2:0];
    pin   = digit_pin_map_i[5'(next3) * 5'd3 +: 3];
    res_o.digit_select  = 8'd1 << pin;
    res_o.segment_drive = pat_q[next3];
    res_o.scan_digit    = next3;
  end

  // Update of the stored digits and the two positions.
  always_comb begin
    pat_d   = pat_q;
    wp_d    = wp_q;
    sp_d    = sp_q;
    wp_prev = wp_q - 4'd1;
    if (cmd_i.valid) begin
      case (cmd_i.kind)
        ssts_pkg::KIND_CHAR: begin
          if (wp_q < count_i) begin
            if (cmd_i.is_period) begin
              // A period drops the dot of the digit before it.
              for (int i = 0; i < ssts_pkg::MAX_DIGITS; i++) begin
                if ((wp_q != 4'd0) && (4'(i) == wp_prev)) begin
                  pat_d[i] = pat_q[i] & ~(8'd1 << dot_bit_i);
                end
              end
            end else begin
              for (int i = 0; i < ssts_pkg::MAX_DIGITS; i++) begin
                if (4'(i) == wp_q) begin
                  pat_d[i] = cmd_i.pattern;
                end
              end
              wp_d = wp_q + 4'd1;
            end
          end
        end
        ssts_pkg::KIND_EOS: begin
          // Fill every digit from the write position up to the count.
          for (int i = 0; i < ssts_pkg::MAX_DIGITS; i++) begin
            if ((4'(i) >= wp_q) && (4'(i) < count_i)) begin
              pat_d[i] = fill_pattern_i;
            end
          end
          wp_d = 4'd0;
        end
        ssts_pkg::KIND_TICK: begin
          sp_d = next3;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 4'd0;
      sp_q <= 3'd0;
      for (int i = 0; i < ssts_pkg::MAX_DIGITS; i++) begin
        pat_q[i] <= 8'd0;
      end
    end else begin
      wp_q <= wp_d;
      sp_q <= sp_d;
      pat_q <= pat_d;
    end
  end

  // The write position never passes the number of digits.
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= 4'(ssts_pkg::MAX_DIGITS))
    else $error("write position beyond the last digit");

  // A scan tick leaves the scan position at the digit it reported.
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && (cmd_i.kind == ssts_pkg::KIND_TICK)) |=> (sp_q == $past(res_o.scan_digit)))
    else $error("scan position does not follow the reported digit");

  // End of string always rewinds the write position.
  a_eos_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && (cmd_i.kind == ssts_pkg::KIND_EOS)) |=> (wp_q == 4'd0))
    else $error("end of string did not rewind the write position");

endmodule

### sv/seven_segment_text_scanner.sv
// A scan tick passes from the item stage register into the output register, and waits in
// the item stage while a result is still untaken; other kinds of item produce no result.
// Throughput: one item per cycle, set by the single update of the digit bank per cycle;
// the input stalls only while a tick in the item stage waits on an untaken scan result.
// Reset (rst_ni, asynchronous, active low) restores the configuration registers, clears
// the digits and both positions; the glyph RAM keeps its contents and must be loaded before use.
module seven_segment_text_scanner #(
  parameter int GLYPH_SLOTS = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssts_in_if.sink           in_i,
  ssts_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(GLYPH_SLOTS);

  // Configuration registers.
  logic [3:0]  dc_q;
  logic [23:0] dpm_q;
  logic [3:0]  sc_q;
  logic [23:0] spm_q;
  logic [2:0]  db_q;
  logic [7:0]  fp_q;
  logic        cfg_we;
  ssts_pkg::reg_e reg_sel;

  // Item stage.
  logic                 s1_valid_q, s1_valid_d;
  ssts_pkg::kind_e      s1_kind_q;
  logic [7:0]           s1_char_q;
  logic                 s1_glyph_q;
  logic                 in_acc;
  logic                 advance;
  ssts_pkg::kind_e      in_kind;

  // Character decode.
  logic [7:0]    slot_w;
  logic          glyph_char;
  logic          glyph_ok;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic [7:0]    logical;
  logic [3:0]    count;

  ssts_pkg::digit_cmd_t cmd;
  ssts_pkg::scan_res_t  res;
  ssts_pkg::scan_res_t  out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;

  // Register port: writes in the access phase, reads always return the register.
  assign pready  = 1'b1;
  assign reg_sel = ssts_pkg::reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q  <= ssts_pkg::RST_DIGIT_COUNT;
      dpm_q <= ssts_pkg::RST_DIGIT_PIN_MAP;
      sc_q  <= ssts_pkg::RST_SEGMENT_COUNT;
      spm_q <= ssts_pkg::RST_SEGMENT_PIN_MAP;
      db_q  <= ssts_pkg::RST_DOT_BIT;
      fp_q  <= ssts_pkg::RST_FILL_PATTERN;
    end else if (cfg_we) begin
      case (reg_sel)
        ssts_pkg::REG_DIGIT_COUNT:     dc_q  <= pwdata[3:0];
        ssts_pkg::REG_DIGIT_PIN_MAP:   dpm_q <= pwdata[23:0];
        ssts_pkg::REG_SEGMENT_COUNT:   sc_q  <= pwdata[3:0];
        ssts_pkg::REG_SEGMENT_PIN_MAP: spm_q <= pwdata[23:0];
        ssts_pkg::REG_DOT_BIT:         db_q  <= pwdata[2:0];
        ssts_pkg::REG_FILL_PATTERN:    fp_q  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ssts_pkg::REG_DIGIT_COUNT:     prdata = {28'd0, dc_q};
      ssts_pkg::REG_DIGIT_PIN_MAP:   prdata = {8'd0, dpm_q};
      ssts_pkg::REG_SEGMENT_COUNT:   prdata = {28'd0, sc_q};
      ssts_pkg::REG_SEGMENT_PIN_MAP: prdata = {8'd0, spm_q};
      ssts_pkg::REG_DOT_BIT:         prdata = {29'd0, db_q};
      ssts_pkg::REG_FILL_PATTERN:    prdata = {24'd0, fp_q};
      default:                       prdata = 32'd0;
    endcase
  end

  // Digits in use: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    count = dc_q;
    if (dc_q == 4'd0) begin
      count = 4'd1;
    end else if (dc_q > 4'(ssts_pkg::MAX_DIGITS)) begin
      count = 4'(ssts_pkg::MAX_DIGITS);
    end
  end

  // Glyph slot of a digit or a letter of either case.
  always_comb begin
    slot_w     = 8'd0;
    glyph_char = 1'b0;
    if ((in_i.char_code >= ssts_pkg::CHAR_0) && (in_i.char_code <= ssts_pkg::CHAR_9)) begin
      slot_w     = in_i.char_code - ssts_pkg::CHAR_0;
      glyph_char = 1'b1;
    end else if ((in_i.char_code >= ssts_pkg::CHAR_LOW_A) &&
                 (in_i.char_code <= ssts_pkg::CHAR_LOW_Z)) begin
      slot_w     = in_i.char_code - ssts_pkg::CHAR_LOW_A + ssts_pkg::LETTER_BASE;
      glyph_char = 1'b1;
    end else if ((in_i.char_code >= ssts_pkg::CHAR_UP_A) &&
                 (in_i.char_code <= ssts_pkg::CHAR_UP_Z)) begin
      slot_w     = in_i.char_code - ssts_pkg::CHAR_UP_A + ssts_pkg::LETTER_BASE;
      glyph_char = 1'b1;
    end
    glyph_ok = glyph_char && (slot_w < 8'(GLYPH_SLOTS));
  end

  // Input handshake: the stage frees up whenever its item moves on.
  assign in_kind  = ssts_pkg::kind_e'(in_i.kind);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc   = in_i.valid && in_i.ready;
  assign ram_we   = in_acc && (in_kind == ssts_pkg::KIND_GLYPH) &&
                    ({2'b00, in_i.glyph_index} < 8'(GLYPH_SLOTS));
  assign ram_re   = in_acc && (in_kind == ssts_pkg::KIND_CHAR) && glyph_ok;

  ssts_glyph_ram #(
    .DEPTH (GLYPH_SLOTS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.glyph_index[AW-1:0]),
    .wdata_i (in_i.glyph_pattern),
    .re_i    (ram_re),
    .raddr_i (slot_w[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Item stage register.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= in_kind;
      s1_char_q  <= in_i.char_code;
      s1_glyph_q <= glyph_ok;
    end
  end

  // A tick moves on only when the output register is free or being emptied.
  assign advance  = s1_valid_q && ((s1_kind_q != ssts_pkg::KIND_TICK) ||
                                   !out_valid_q || out_o.ready);
  assign out_load = advance && (s1_kind_q == ssts_pkg::KIND_TICK);

  // Pattern lookup and pin remap for the staged item.
  assign logical = s1_glyph_q ? ram_rdata : ssts_pkg::punct_pattern(s1_char_q);

  always_comb begin
    cmd.valid     = advance;
    cmd.kind      = s1_kind_q;
    cmd.is_period = (s1_char_q == ssts_pkg::CHAR_PERIOD);
    cmd.pattern   = ssts_pkg::remap_segments(logical, sc_q, spm_q);
  end

  ssts_digit_bank u_digit_bank (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .count_i         (count),
    .digit_pin_map_i (dpm_q),
    .dot_bit_i       (db_q),
    .fill_pattern_i  (fp_q),
    .res_o           (res)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.digit_select  = out_q.digit_select;
  assign out_o.segment_drive = out_q.segment_drive;
  assign out_o.scan_digit    = out_q.scan_digit;

  // A new result never replaces one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("scan result overwritten before it was taken");

  // The item stage is never loaded while it still holds an item that cannot move.
  a_stage_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!s1_valid_q || advance))
    else $error("item stage overwritten");

  // A waiting result stays offered and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_q)))
    else $error("waiting scan result changed before it was taken");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int GLYPHS        = 36;
  localparam int IDLE_PERCENT  = 17;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 80;
  localparam int PHASE_ITEMS   = 150;
  localparam int CYCLE_LIMIT   = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ssts_in_if  in_bus ();
  ssts_out_if out_bus ();

  seven_segment_text_scanner DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the display state and its registers.
  logic [7:0]  digit_pat [ssts_pkg::MAX_DIGITS];
  logic [7:0]  glyph_tab [GLYPHS];
  bit          glyph_loaded [GLYPHS];
  logic [3:0]  wr_pos;
  logic [2:0]  scan_pos;
  logic [3:0]  cfg_digit_count;
  logic [23:0] cfg_digit_pin_map;
  logic [3:0]  cfg_segment_count;
  logic [23:0] cfg_segment_pin_map;
  logic [2:0]  cfg_dot_bit;
  logic [7:0]  cfg_fill;

  ssts_pkg::scan_res_t pending_scans [$];
  int          failures = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          idle_off = 1'b0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Digits actually in use: zero acts as one, anything above the maximum as the maximum.
  function automatic int digits_in_use();
    if (cfg_digit_count == 4'd0) return 1;
    if (cfg_digit_count > 4'(ssts_pkg::MAX_DIGITS)) return ssts_pkg::MAX_DIGITS;
    return int'(cfg_digit_count);
  endfunction

  // Glyph slot of a digit or a letter of either case; -1 for anything else.
  function automatic int glyph_slot(input logic [7:0] c);
    if (c >= ssts_pkg::CHAR_0 && c <= ssts_pkg::CHAR_9) return int'(c - ssts_pkg::CHAR_0);
    if (c >= ssts_pkg::CHAR_LOW_A && c <= ssts_pkg::CHAR_LOW_Z) begin
      return int'(c - ssts_pkg::CHAR_LOW_A) + int'(ssts_pkg::LETTER_BASE);
    end
    if (c >= ssts_pkg::CHAR_UP_A && c <= ssts_pkg::CHAR_UP_Z) begin
      return int'(c - ssts_pkg::CHAR_UP_A) + int'(ssts_pkg::LETTER_BASE);
    end
    return -1;
  endfunction

  // Logical segment bits of a character.
  function automatic logic [7:0] logical_of(input logic [7:0] c);
    int slot;
    slot = glyph_slot(c);
    if (slot >= 0) return (slot < GLYPHS) ? glyph_tab[slot] : ssts_pkg::PAT_BLANK;
    case (c)
      ssts_pkg::CHAR_CARET:  return ssts_pkg::PAT_CARET;
      ssts_pkg::CHAR_COMMA:  return ssts_pkg::PAT_COMMA;
      ssts_pkg::CHAR_MINUS:  return ssts_pkg::PAT_MINUS;
      ssts_pkg::CHAR_UNDER:  return ssts_pkg::PAT_UNDER;
      ssts_pkg::CHAR_EQUALS: return ssts_pkg::PAT_EQUALS;
      ssts_pkg::CHAR_PERIOD: return ssts_pkg::PAT_PERIOD;
      default:               return ssts_pkg::PAT_BLANK;
    endcase
  endfunction

  // Physical active-low byte for a logical pattern under the current segment map.
  function automatic logic [7:0] drive_of(input logic [7:0] logical);
    int         n;
    logic [7:0] lit;
    n = (cfg_segment_count > 4'(ssts_pkg::SEGMENT_BITS)) ? ssts_pkg::SEGMENT_BITS :
                                                          int'(cfg_segment_count);
    lit = '0;
    for (int i = 0; i < n; i++) begin
      if (logical[i]) lit[cfg_segment_pin_map[3*i +: 3]] = 1'b1;
    end
    return ~lit;
  endfunction

  // Update the shadow display for one accepted item; a scan tick queues its result.
  function automatic void apply_item(input logic [1:0] kind, input logic [7:0] c,
                                     input logic [5:0] idx, input logic [7:0] pat);
    int                  count;
    int                  nxt;
    ssts_pkg::scan_res_t res;
    count = digits_in_use();
    case (kind)
      ssts_pkg::KIND_CHAR: begin
        if (wr_pos < count) begin
          if (c == ssts_pkg::CHAR_PERIOD) begin
            if (wr_pos > 0) digit_pat[wr_pos - 4'd1] &= ~(8'd1 << cfg_dot_bit);
          end else begin
            digit_pat[wr_pos] = drive_of(logical_of(c));
            wr_pos = wr_pos + 4'd1;
          end
        end
      end
      ssts_pkg::KIND_EOS: begin
        for (int p = int'(wr_pos); p < count; p++) digit_pat[p] = cfg_fill;
        wr_pos = '0;
      end
      ssts_pkg::KIND_TICK: begin
        nxt = scan_pos + 1;
        if (nxt >= count) nxt = 0;
        scan_pos = 3'(nxt);
        res.digit_select  = 8'd1 << cfg_digit_pin_map[3*nxt +: 3];
        res.segment_drive = digit_pat[nxt];
        res.scan_digit    = 3'(nxt);
        pending_scans.push_back(res);
      end
      default: begin
        if (idx < GLYPHS) begin
          glyph_tab[idx]    = pat;
          glyph_loaded[idx] = 1'b1;
        end
      end
    endcase
  endfunction

  // Offer one item, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] c,
                           input logic [5:0] idx, input logic [7:0] pat);
    while (!idle_off && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.kind          <= kind;
    in_bus.char_code     <= c;
    in_bus.glyph_index   <= idx;
    in_bus.glyph_pattern <= pat;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    apply_item(kind, c, idx, pat);
    items_sent++;
  endtask

  // A character; a glyph slot is always loaded before a character reads it.
  task automatic send_char(input logic [7:0] c);
    int slot;
    slot = glyph_slot(c);
    if (slot >= 0 && slot < GLYPHS && !glyph_loaded[slot]) begin
      send_item(ssts_pkg::KIND_GLYPH, 8'($urandom), 6'(slot), 8'($urandom));
    end
    send_item(ssts_pkg::KIND_CHAR, c, 6'($urandom), 8'($urandom));
  endtask

  task automatic send_tick();
    send_item(ssts_pkg::KIND_TICK, 8'($urandom), 6'($urandom), 8'($urandom));
  endtask

  task automatic send_eos();
    send_item(ssts_pkg::KIND_EOS, 8'($urandom), 6'($urandom), 8'($urandom));
  endtask

  // Random character, weighted towards digits, letters and the punctuation marks.
  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return ssts_pkg::CHAR_0 + 8'($urandom_range(0, 9));
      3:       return ssts_pkg::CHAR_LOW_A + 8'($urandom_range(0, 25));
      4:       return ssts_pkg::CHAR_UP_A + 8'($urandom_range(0, 25));
      5: begin
        case ($urandom_range(0, 5))
          0:       return ssts_pkg::CHAR_CARET;
          1:       return ssts_pkg::CHAR_COMMA;
          2:       return ssts_pkg::CHAR_MINUS;
          3:       return ssts_pkg::CHAR_UNDER;
          4:       return ssts_pkg::CHAR_EQUALS;
          default: return 8'h20;
        endcase
      end
      6, 7:    return ssts_pkg::CHAR_PERIOD;
      default: return 8'($urandom);
    endcase
  endfunction

  // Drop valid, wait for every scan result, then let the pipeline drain.
  task automatic settle_display();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input ssts_pkg::reg_e index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      ssts_pkg::REG_DIGIT_COUNT:     cfg_digit_count     = value[3:0];
      ssts_pkg::REG_DIGIT_PIN_MAP:   cfg_digit_pin_map   = value[23:0];
      ssts_pkg::REG_SEGMENT_COUNT:   cfg_segment_count   = value[3:0];
      ssts_pkg::REG_SEGMENT_PIN_MAP: cfg_segment_pin_map = value[23:0];
      ssts_pkg::REG_DOT_BIT:         cfg_dot_bit         = value[2:0];
      ssts_pkg::REG_FILL_PATTERN:    cfg_fill            = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] dc, input logic [23:0] dmap,
                           input logic [3:0] sc, input logic [23:0] smap,
                           input logic [2:0] dot, input logic [7:0] fill);
    settle_display();
    write_reg(ssts_pkg::REG_DIGIT_COUNT, 32'(dc));
    write_reg(ssts_pkg::REG_DIGIT_PIN_MAP, 32'(dmap));
    write_reg(ssts_pkg::REG_SEGMENT_COUNT, 32'(sc));
    write_reg(ssts_pkg::REG_SEGMENT_PIN_MAP, 32'(smap));
    write_reg(ssts_pkg::REG_DOT_BIT, 32'(dot));
    write_reg(ssts_pkg::REG_FILL_PATTERN, 32'(fill));
  endtask

  // Mostly whole strings followed by scans; the rest is noise and glyph loads.
  task automatic random_text(input int n);
    int target;
    int len;
    int kind_pick;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          len = $urandom_range(0, 10);
          for (int i = 0; i < len; i++) send_char(random_char());
          send_eos();
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) send_tick();
        end
        7, 8: begin
          kind_pick = $urandom_range(0, 3);
          if (kind_pick == int'(ssts_pkg::KIND_CHAR)) send_char(8'($urandom));
          else send_item(2'(kind_pick), 8'($urandom), 6'($urandom), 8'($urandom));
        end
        default: send_item(ssts_pkg::KIND_GLYPH, 8'($urandom), 6'($urandom_range(0, 63)),
                           8'($urandom));
      endcase
    end
  endtask

  // Loads at both ends of the table and beyond it.
  task automatic test_glyph_loads();
    send_item(ssts_pkg::KIND_GLYPH, 8'h00, 6'd0, 8'hFF);
    send_item(ssts_pkg::KIND_GLYPH, 8'hFF, 6'd10, 8'hA5);
    send_item(ssts_pkg::KIND_GLYPH, 8'h00, 6'd35, 8'h5A);
    send_item(ssts_pkg::KIND_GLYPH, 8'hFF, 6'd63, 8'hFF);
  endtask

  // Strings under the reset settings: periods, full display, fill and scan wrap.
  task automatic test_display_strings();
    send_char(ssts_pkg::CHAR_EQUALS);
    send_char(ssts_pkg::CHAR_LOW_A);
    send_char(ssts_pkg::CHAR_PERIOD);
    send_char(ssts_pkg::CHAR_UP_Z);
    send_eos();
    repeat (5) send_tick();
    send_char(ssts_pkg::CHAR_PERIOD);
    send_char(ssts_pkg::CHAR_0);
    send_char(ssts_pkg::CHAR_CARET);
    send_char(ssts_pkg::CHAR_COMMA);
    send_char(ssts_pkg::CHAR_MINUS);
    send_char(ssts_pkg::CHAR_UNDER);
    send_char(ssts_pkg::CHAR_PERIOD);
    send_eos();
    repeat (4) send_tick();
  endtask

  // Extreme register settings, one phase of traffic each; one phase runs with no idling.
  task automatic test_register_settings();
    configure(4'd8, 24'hFAC688, 4'd8, 24'h05397E, 3'd7, 8'hFF);
    random_text(PHASE_ITEMS);
    configure(4'd1, 24'h000000, 4'd0, 24'h000000, 3'd0, 8'h00);
    random_text(PHASE_ITEMS);
    configure(4'd0, 24'hFFFFFF, 4'd15, 24'hFFFFFF, 3'd7, 8'hAA);
    random_text(PHASE_ITEMS);
    configure(4'd15, 24'h1A2B3C, 4'd7, 24'hC3B2A1, 3'd3, 8'h55);
    idle_off = 1'b1;
    random_text(PHASE_ITEMS);
    idle_off = 1'b0;
  endtask

  // The receiver holds off while ticks keep coming, so the input must stall.
  task automatic test_output_backpressure();
    configure(4'd8, 24'hFAC688, 4'd8, 24'hFAC688, 3'd2, 8'h3C);
    idle_off = 1'b1;
    hold_requests++;
    repeat (30) send_tick();
    random_text(40);
    idle_off = 1'b0;
  endtask

  // Random register settings with random traffic.
  task automatic test_random_settings();
    repeat (7) begin
      configure(4'($urandom_range(0, 15)), 24'($urandom), 4'($urandom_range(0, 15)),
                24'($urandom), 3'($urandom_range(0, 7)), 8'($urandom));
      random_text(PHASE_ITEMS);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= idle_off || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare every accepted scan result with the oldest expectation.
  always @(posedge clk_i) begin
    ssts_pkg::scan_res_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_scans.size() == 0) begin
        $error("scan result with none expected: digit_select %h segment_drive %h scan_digit %0d",
               out_bus.digit_select, out_bus.segment_drive, out_bus.scan_digit);
        failures++;
      end else begin
        want = pending_scans.pop_front();
        if (out_bus.digit_select !== want.digit_select) begin
          $error("digit_select: expected %h, actual %h", want.digit_select, out_bus.digit_select);
          failures++;
        end
        if (out_bus.segment_drive !== want.segment_drive) begin
          $error("segment_drive: expected %h, actual %h",
                 want.segment_drive, out_bus.segment_drive);
          failures++;
        end
        if (out_bus.scan_digit !== want.scan_digit) begin
          $error("scan_digit: expected %0d, actual %0d", want.scan_digit, out_bus.scan_digit);
          failures++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.kind          = ssts_pkg::KIND_CHAR;
    in_bus.char_code     = '0;
    in_bus.glyph_index   = '0;
    in_bus.glyph_pattern = '0;
    for (int i = 0; i < ssts_pkg::MAX_DIGITS; i++) digit_pat[i] = '0;
    for (int i = 0; i < GLYPHS; i++) begin
      glyph_tab[i]    = '0;
      glyph_loaded[i] = 1'b0;
    end
    wr_pos              = '0;
    scan_pos            = '0;
    cfg_digit_count     = ssts_pkg::RST_DIGIT_COUNT;
    cfg_digit_pin_map   = ssts_pkg::RST_DIGIT_PIN_MAP;
    cfg_segment_count   = ssts_pkg::RST_SEGMENT_COUNT;
    cfg_segment_pin_map = ssts_pkg::RST_SEGMENT_PIN_MAP;
    cfg_dot_bit         = ssts_pkg::RST_DOT_BIT;
    cfg_fill            = ssts_pkg::RST_FILL_PATTERN;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_glyph_loads();
    test_display_strings();
    test_register_settings();
    test_output_backpressure();
    test_random_settings();

    settle_display();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### seven_segment_text_scanner.f
sv/ssts_pkg.sv
sv/ssts_in_if.sv
sv/ssts_out_if.sv
sv/ssts_glyph_ram.sv
sv/ssts_digit_bank.sv
sv/seven_segment_text_scanner.sv
sim/testbench.sv
